// ===== src/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

    // Field widths fixed by the stream payload
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 11;
    localparam int FRAME_W = 10;
    localparam int COUNT_W = 11;
    localparam int REF_W   = 8;
    localparam int CFG_W   = 11;

    // Bitmap word geometry
    localparam int WORD_W     = 32;
    localparam int WORD_SEL_W = 5;

    localparam logic [REF_W-1:0] REF_MAX = 8'hFF;

    // Configuration register indexes and reset values
    localparam logic [0:0] CFG_LOW_END    = 1'b0;
    localparam logic [0:0] CFG_HIGH_START = 1'b1;
    localparam logic [CFG_W-1:0] LOW_END_RST    = 11'd304;
    localparam logic [CFG_W-1:0] HIGH_START_RST = 11'd768;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT    = 3'd0,
        MODE_ALLOC   = 3'd1,
        MODE_FREE    = 3'd2,
        MODE_COUNT   = 3'd3,
        MODE_REF_INC = 3'd4,
        MODE_REF_DEC = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_FREE  = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_RELEASED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR      = 3'd0,
        S_IDLE       = 3'd1,
        S_SWEEP      = 3'd2,
        S_SCAN_START = 3'd3,
        S_SCAN       = 3'd4,
        S_READ       = 3'd5,
        S_EXEC       = 3'd6,
        S_DONE       = 3'd7
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic sweep_step;
        logic sweep_mark;
        logic init_total;
        logic scan_step;
        logic alloc_chk;
        logic exec;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic scan_hit;
        logic scan_last;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/bfa_ram.sv =====
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/bfa_ctrl.sv =====
`default_nettype none

module bfa_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire bfa_pkg::mode_t in_mode,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output bfa_pkg::cmd_t       cmd,
    input  wire bfa_pkg::stat_t st
);

    bfa_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;

    // State and output valid registers; reset starts the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bfa_pkg::S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            bfa_pkg::S_CLEAR: begin
                cmd.sweep_step = 1'b1;
                if (st.sweep_last) begin
                    state_next = bfa_pkg::S_IDLE;
                end
            end
            bfa_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    unique case (in_mode)
                        bfa_pkg::MODE_INIT:    state_next = bfa_pkg::S_SWEEP;
                        bfa_pkg::MODE_ALLOC:   state_next = bfa_pkg::S_SCAN_START;
                        bfa_pkg::MODE_FREE,
                        bfa_pkg::MODE_REF_INC,
                        bfa_pkg::MODE_REF_DEC: state_next = bfa_pkg::S_READ;
                        default:               state_next = bfa_pkg::S_DONE;
                    endcase
                end
            end
            bfa_pkg::S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_mark = 1'b1;
                if (st.sweep_last) begin
                    cmd.init_total = 1'b1;
                    state_next     = bfa_pkg::S_DONE;
                end
            end
            bfa_pkg::S_SCAN_START: begin
                cmd.scan_step = 1'b1;
                state_next    = bfa_pkg::S_SCAN;
            end
            bfa_pkg::S_SCAN: begin
                cmd.scan_step = 1'b1;
                cmd.alloc_chk = 1'b1;
                if (st.scan_hit || st.scan_last) begin
                    state_next = bfa_pkg::S_DONE;
                end
            end
            bfa_pkg::S_READ: begin
                state_next = bfa_pkg::S_EXEC;
            end
            bfa_pkg::S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = bfa_pkg::S_DONE;
            end
            bfa_pkg::S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = bfa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bfa_pkg::S_IDLE;
            end
        endcase
    end

    // Hold the result until the transfer completes
    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in progress");

    a_out_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input accepted before clearing pass");

endmodule

`default_nettype wire

// ===== src/bfa_dp.sv =====
`default_nettype none

module bfa_dp #(
    parameter int FRAME_TOTAL = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bfa_pkg::cmd_t                 cmd,
    output bfa_pkg::stat_t                     st,
    input  wire logic [bfa_pkg::MODE_W-1:0]    in_mode,
    input  wire logic [bfa_pkg::INDEX_W-1:0]   in_frame_index,
    input  wire logic                          cfg_we,
    input  wire logic [0:0]                    cfg_index,
    input  wire logic [bfa_pkg::CFG_W-1:0]     cfg_wdata,
    output logic      [1:0]                    out_status,
    output logic      [bfa_pkg::FRAME_W-1:0]   out_result_frame,
    output logic      [bfa_pkg::COUNT_W-1:0]   out_free_count,
    output logic      [bfa_pkg::REF_W-1:0]     out_ref_count
);

    localparam int WORDS = (FRAME_TOTAL + bfa_pkg::WORD_W - 1) / bfa_pkg::WORD_W;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SAW   = $clog2(FRAME_TOTAL);
    localparam int FCW   = $clog2(FRAME_TOTAL + 1);
    localparam int CMPW  = (WAW + 6 > 12) ? WAW + 6 : 12;

    // Request and configuration registers
    bfa_pkg::mode_t                mode_reg;
    logic [bfa_pkg::INDEX_W-1:0]   idx_reg;
    logic [bfa_pkg::CFG_W-1:0]     low_reg, high_reg;
    logic [FCW-1:0]                free_total_reg, free_total_next;
    logic [SAW-1:0]                cnt_reg, cnt_next;
    logic [WAW-1:0]                data_word_reg;

    // Pending result and output registers
    bfa_pkg::status_t              res_status_reg, res_status_next;
    logic [bfa_pkg::FRAME_W-1:0]   res_frame_reg, res_frame_next;
    logic [bfa_pkg::REF_W-1:0]     res_ref_reg, res_ref_next;

    // Memory ports
    logic                          bmp_we, shr_we;
    logic [WAW-1:0]                bmp_waddr, bmp_raddr;
    logic [bfa_pkg::WORD_W-1:0]    bmp_wdata, bmp_rdata;
    logic [SAW-1:0]                shr_waddr, shr_raddr;
    logic [bfa_pkg::REF_W-1:0]     shr_wdata, shr_rdata;

    logic [WAW-1:0]                idx_word;
    logic [bfa_pkg::WORD_SEL_W-1:0] idx_bit;
    logic                          in_range;
    logic                          bit_used;
    logic [bfa_pkg::WORD_W-1:0]    sweep_word;
    logic                          sweep_wr;
    logic [bfa_pkg::WORD_SEL_W-1:0] hit_pos;
    logic                          hit;
    logic [bfa_pkg::REF_W-1:0]     ref_inc, ref_dec, ref_new;
    logic                          clr_bit;
    logic [CMPW-1:0]               lim_low, lim_high;
    logic [FCW-1:0]                init_free;

    assign idx_word = WAW'(idx_reg >> bfa_pkg::WORD_SEL_W);
    assign idx_bit  = idx_reg[bfa_pkg::WORD_SEL_W-1:0];
    assign in_range = CMPW'(idx_reg) < CMPW'(FRAME_TOTAL);
    assign bit_used = bmp_rdata[idx_bit];
    assign sweep_wr = cmd.sweep_step && (cnt_reg < SAW'(WORDS));

    // Build a sweep word: frames past FRAME_TOTAL, or outside low..high in init, are used
    always_comb begin
        logic [CMPW-1:0] f;
        for (int j = 0; j < bfa_pkg::WORD_W; j++) begin
            f = CMPW'({cnt_reg[WAW-1:0], 5'(j)});
            sweep_word[j] = (f >= CMPW'(FRAME_TOTAL))
                || (cmd.sweep_mark && ((f < CMPW'(low_reg)) || (f >= CMPW'(high_reg))));
        end
    end

    // Free frames after init lie between the clipped bounds
    always_comb begin
        lim_low  = (CMPW'(low_reg) > CMPW'(FRAME_TOTAL)) ? CMPW'(FRAME_TOTAL)
                                                         : CMPW'(low_reg);
        lim_high = (CMPW'(high_reg) > CMPW'(FRAME_TOTAL)) ? CMPW'(FRAME_TOTAL)
                                                          : CMPW'(high_reg);
        init_free = (lim_high > lim_low) ? FCW'(lim_high - lim_low) : '0;
    end

    // Find the lowest clear bit of the word under scan
    always_comb begin
        hit_pos = '0;
        for (int j = bfa_pkg::WORD_W - 1; j >= 0; j--) begin
            if (!bmp_rdata[j]) begin
                hit_pos = 5'(j);
            end
        end
        hit = ~&bmp_rdata;
    end

    assign ref_inc = (shr_rdata != bfa_pkg::REF_MAX) ? shr_rdata + 8'd1 : shr_rdata;
    assign ref_dec = (shr_rdata != '0) ? shr_rdata - 8'd1 : '0;

    // Execute free and reference operations; every sweep step zeroes one share count
    always_comb begin
        clr_bit         = 1'b0;
        shr_we          = cmd.sweep_step;
        ref_new         = ref_inc;
        res_status_next = res_status_reg;
        res_frame_next  = res_frame_reg;
        res_ref_next    = res_ref_reg;
        if (cmd.capture) begin
            res_status_next = bfa_pkg::STAT_OK;
            res_frame_next  = '0;
            res_ref_next    = '0;
        end else if (cmd.alloc_chk) begin
            if (hit) begin
                res_frame_next = bfa_pkg::FRAME_W'({data_word_reg, hit_pos});
            end else if (st.scan_last) begin
                res_status_next = bfa_pkg::STAT_NO_FREE;
            end
        end else if (cmd.exec) begin
            if (!in_range) begin
                res_status_next = bfa_pkg::STAT_RANGE;
            end else begin
                unique case (mode_reg)
                    bfa_pkg::MODE_FREE: begin
                        clr_bit = bit_used;
                    end
                    bfa_pkg::MODE_REF_INC: begin
                        shr_we       = 1'b1;
                        ref_new      = ref_inc;
                        res_ref_next = ref_inc;
                    end
                    bfa_pkg::MODE_REF_DEC: begin
                        shr_we       = 1'b1;
                        ref_new      = ref_dec;
                        res_ref_next = ref_dec;
                        if (ref_dec == '0 && bit_used) begin
                            clr_bit         = 1'b1;
                            res_status_next = bfa_pkg::STAT_RELEASED;
                        end
                    end
                    default: begin
                        clr_bit = 1'b0;
                    end
                endcase
            end
        end
    end

    // Memory port selection
    always_comb begin
        bmp_raddr = cmd.scan_step ? cnt_reg[WAW-1:0] : idx_word;
        shr_raddr = SAW'(idx_reg);
        bmp_we    = 1'b0;
        bmp_waddr = idx_word;
        bmp_wdata = bmp_rdata & ~(bfa_pkg::WORD_W'(1) << idx_bit);
        shr_waddr = SAW'(idx_reg);
        shr_wdata = ref_new;
        if (cmd.sweep_step) begin
            bmp_we    = sweep_wr;
            bmp_waddr = cnt_reg[WAW-1:0];
            bmp_wdata = sweep_word;
            shr_waddr = cnt_reg;
            shr_wdata = '0;
        end else if (cmd.alloc_chk) begin
            bmp_we    = hit;
            bmp_waddr = data_word_reg;
            bmp_wdata = bmp_rdata | (bfa_pkg::WORD_W'(1) << hit_pos);
        end else begin
            bmp_we = clr_bit;
        end
    end

    // Running free total
    always_comb begin
        free_total_next = free_total_reg;
        if (cmd.init_total) begin
            free_total_next = init_free;
        end else if (cmd.alloc_chk && hit) begin
            free_total_next = free_total_reg - FCW'(1);
        end else if (clr_bit) begin
            free_total_next = free_total_reg + FCW'(1);
        end
    end

    // Sweep and scan counter
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.capture) begin
            cnt_next = '0;
        end else if (cmd.sweep_step) begin
            cnt_next = cnt_reg + SAW'(1);
        end else if (cmd.scan_step && (cnt_reg != SAW'(WORDS - 1))) begin
            cnt_next = cnt_reg + SAW'(1);
        end
    end

    assign st.sweep_last = (cnt_reg == SAW'(FRAME_TOTAL - 1));
    assign st.scan_hit   = hit;
    assign st.scan_last  = (data_word_reg == WAW'(WORDS - 1));

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            free_total_reg <= FCW'(FRAME_TOTAL);
            low_reg        <= bfa_pkg::LOW_END_RST;
            high_reg       <= bfa_pkg::HIGH_START_RST;
        end else begin
            cnt_reg        <= cnt_next;
            free_total_reg <= free_total_next;
            if (cfg_we && cfg_index == bfa_pkg::CFG_LOW_END) begin
                low_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == bfa_pkg::CFG_HIGH_START) begin
                high_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= bfa_pkg::mode_t'(in_mode);
            idx_reg  <= in_frame_index;
        end
        if (cmd.scan_step) begin
            data_word_reg <= cnt_reg[WAW-1:0];
        end
        res_status_reg <= res_status_next;
        res_frame_reg  <= res_frame_next;
        res_ref_reg    <= res_ref_next;
        if (cmd.load_out) begin
            out_status       <= res_status_reg;
            out_result_frame <= res_frame_reg;
            out_free_count   <= bfa_pkg::COUNT_W'(free_total_reg);
            out_ref_count    <= res_ref_reg;
        end
    end

    bfa_ram #(
        .WIDTH(bfa_pkg::WORD_W),
        .DEPTH(WORDS)
    ) u_bitmap (
        .aclk (aclk),
        .we   (bmp_we),
        .waddr(bmp_waddr),
        .wdata(bmp_wdata),
        .raddr(bmp_raddr),
        .rdata(bmp_rdata)
    );

    bfa_ram #(
        .WIDTH(bfa_pkg::REF_W),
        .DEPTH(FRAME_TOTAL)
    ) u_share (
        .aclk (aclk),
        .we   (shr_we),
        .waddr(shr_waddr),
        .wdata(shr_wdata),
        .raddr(shr_raddr),
        .rdata(shr_rdata)
    );

endmodule

`default_nettype wire

// ===== src/bitmap_frame_allocator_refcount_core.sv =====
// Channel   Dir  Payload (lowest bit first)                           Handshake
// s_        in   mode[2:0], frame_index[13:3]                         tvalid/tready
// m_        out  status[1:0], result_frame[11:2], free_count[22:12],  tvalid/tready
//                ref_count[30:23]
// cfg_      in   cfg_index selects low end (0) or high start (1)      cfg_we
//
// One request at a time. Alloc reads the used-bit map one 32-bit word per cycle
// through the single bitmap read port. Init clears one share-count entry per cycle.
// After reset a clearing pass runs with s_tready low.
// The result sits in an output register, so the next input is taken while it waits;
// a stalled m_tready holds only the next finishing request until that transfer completes.
`default_nettype none

module bitmap_frame_allocator_refcount_core #(
    parameter int FRAME_TOTAL = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // mode[2:0], frame_index[13:3], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // status, result_frame, free_count, ref_count, pad
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [10:0] cfg_wdata
);

    bfa_pkg::cmd_t  cmd;
    bfa_pkg::stat_t st;

    logic [1:0]                  out_status;
    logic [bfa_pkg::FRAME_W-1:0] out_result_frame;
    logic [bfa_pkg::COUNT_W-1:0] out_free_count;
    logic [bfa_pkg::REF_W-1:0]   out_ref_count;

    bfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .in_mode (bfa_pkg::mode_t'(s_tdata[2:0])),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cmd     (cmd),
        .st      (st)
    );

    bfa_dp #(
        .FRAME_TOTAL(FRAME_TOTAL)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .st              (st),
        .in_mode         (s_tdata[2:0]),
        .in_frame_index  (s_tdata[13:3]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .out_status      (out_status),
        .out_result_frame(out_result_frame),
        .out_free_count  (out_free_count),
        .out_ref_count   (out_ref_count)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {1'b0, out_ref_count, out_free_count, out_result_frame, out_status};

endmodule

`default_nettype wire
